FILE: rtl/core/pfo_pkg.sv
// Shared constants and helpers for the pixel frame orientation block.
`default_nettype none

package pfo_pkg;

    localparam int MAX_DIM = 256;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int DIM_W   = COORD_W + 1;
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int TOTAL_W = ADDR_W + 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int PIX_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int MODE_W     = 2;

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [PIX_W-1:0]   t_pixel;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE   = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam t_dim DIM_MAX = t_dim'(MAX_DIM);
    localparam t_dim DIM_ONE = t_dim'(1);

    function automatic t_dim clamp_dim(input t_dim v);
        t_dim r;
        if (v == '0) begin
            r = DIM_ONE;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfo_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module pfo_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pixel_frame_orientation.sv
// Top level of the pixel frame orientation block: counters, address logic, frame store.
// Latency: a fetch accepted at one edge shows its pixel on the result ports in the
//   following cycle; a load gives no result.
// Throughput: one command per cycle, set by the single frame store port; busy stays low.
// Reset: synchronous, active low; counters clear, sizes go to 256, mode to identity.
// Frame store contents are not cleared; the receiver cannot stall results.
`default_nettype none

module pixel_frame_orientation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_func,
    input  wire pfo_pkg::t_pixel               i_pixel_in,
    output logic                               o_valid,
    output pfo_pkg::t_pixel                    o_pixel_out,
    output logic                               o_row_end,
    output logic                               o_frame_end,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pfo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire pfo_pkg::t_dim                 i_cfg_data
);

    import pfo_pkg::*;

    t_dim                r_frame_width;
    t_dim                r_frame_height;
    logic [MODE_W-1:0]   r_orient_mode;
    t_addr               r_load_index;
    t_coord              r_out_row;
    t_coord              r_out_col;
    logic                r_valid;
    logic                r_row_end;
    logic                r_frame_end;

    t_addr               n_load_index;
    t_coord              n_out_row;
    t_coord              n_out_col;

    logic                accept;
    logic                do_load;
    logic                do_fetch;
    logic [2*DIM_W-1:0]  total_full;
    logic [TOTAL_W-1:0]  total;
    t_addr               load_cur;
    logic [TOTAL_W-1:0]  load_inc;
    t_dim                out_w;
    t_dim                out_h;
    logic                wrap;
    t_coord              row_cur;
    t_coord              col_cur;
    t_coord              src_row;
    t_dim                src_col;
    logic [COORD_W+DIM_W-1:0] row_base;
    logic [COORD_W+DIM_W:0]   addr_sum;
    t_addr               fetch_addr;
    t_addr               ram_addr;
    logic                last_col;
    logic                last_row;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign do_load     = accept && (i_func == FUNC_LOAD);
    assign do_fetch    = accept && (i_func == FUNC_FETCH);

    always_comb begin
        total_full = r_frame_width * r_frame_height;
        total      = total_full[TOTAL_W-1:0];
        load_cur   = ({1'b0, r_load_index} >= total) ? '0 : r_load_index;
        load_inc   = {1'b0, load_cur} + TOTAL_W'(1);
        n_load_index = (load_inc >= total) ? '0 : load_inc[ADDR_W-1:0];
    end

    always_comb begin
        if (r_orient_mode == MODE_ROTATE) begin
            out_h = r_frame_width;
            out_w = r_frame_height;
        end else begin
            out_h = r_frame_height;
            out_w = r_frame_width;
        end
        wrap    = ({1'b0, r_out_row} >= out_h) || ({1'b0, r_out_col} >= out_w);
        row_cur = wrap ? '0 : r_out_row;
        col_cur = wrap ? '0 : r_out_col;

        unique case (r_orient_mode)
            MODE_MIRROR: begin
                src_row = row_cur;
                src_col = r_frame_width - DIM_ONE - {1'b0, col_cur};
            end
            MODE_ROTATE: begin
                src_row = col_cur;
                src_col = r_frame_width - DIM_ONE - {1'b0, row_cur};
            end
            default: begin
                src_row = row_cur;
                src_col = {1'b0, col_cur};
            end
        endcase

        row_base   = src_row * r_frame_width;
        addr_sum   = {1'b0, row_base} + (COORD_W+DIM_W+1)'(src_col);
        fetch_addr = addr_sum[ADDR_W-1:0];

        last_col = ({1'b0, col_cur} == (out_w - DIM_ONE));
        last_row = ({1'b0, row_cur} == (out_h - DIM_ONE));

        if (last_col) begin
            n_out_col = '0;
            n_out_row = last_row ? '0 : row_cur + COORD_W'(1);
        end else begin
            n_out_col = col_cur + COORD_W'(1);
            n_out_row = row_cur;
        end
    end

    assign ram_addr = do_load ? load_cur : fetch_addr;

    pfo_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_re    (do_fetch),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel_in),
        .o_rdata (o_pixel_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_MAX;
            r_frame_height <= DIM_MAX;
            r_orient_mode  <= MODE_IDENTITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= clamp_dim(i_cfg_data);
                REG_FRAME_HEIGHT: r_frame_height <= clamp_dim(i_cfg_data);
                REG_ORIENT_MODE:  r_orient_mode  <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_index <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= do_fetch;
            if (do_load) begin
                r_load_index <= n_load_index;
            end
            if (do_fetch) begin
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fetch) begin
            r_row_end   <= last_col;
            r_frame_end <= last_col && last_row;
        end
    end

    assign o_valid     = r_valid;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire
